// ===== src/cicd_pkg.sv =====
package cicd_pkg;

  // default grid shape
  localparam int GRID_X_DEF = 64;
  localparam int GRID_Y_DEF = 16;

  // field widths
  localparam int CMD_W    = 2;
  localparam int POS_W    = 24;
  localparam int CI_W     = 10;
  localparam int ACC_W    = 40;
  localparam int STATUS_W = 2;
  localparam int CFG_W    = 18;
  localparam int CFG_IDX_W = 1;

  // fixed-point layout of position * inv_cell (Q10.32)
  localparam int FRAC_W  = 16;
  localparam int FRAC_LO = 16;
  localparam int INT_LO  = 32;
  localparam int JW      = 10;
  localparam int WGT_W   = 17;
  localparam int AMT_W   = 20;

  // shared multiplier
  localparam int MUL_A_W = 34;
  localparam int MUL_B_W = 18;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  localparam logic [WGT_W-1:0] ONE_Q16 = WGT_W'(65536);

  // register reset values
  localparam logic [CFG_W-1:0] INV_CELL_RST     = CFG_W'(66665);
  localparam logic [CFG_W-1:0] WEIGHT_SCALE_RST = CFG_W'(68982);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_INV_CELL     = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_SCALE = 1'b1;

  // commands
  localparam logic [CMD_W-1:0] CMD_CLEAR   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DEPOSIT = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ    = 2'd2;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_DROP = 2'd1;
  localparam logic [STATUS_W-1:0] ST_SAT  = 2'd2;

  typedef struct packed {
    logic [MUL_A_W-1:0] a;
    logic [MUL_B_W-1:0] b;
  } mul_op_t;

endpackage

// ===== src/cicd_if.sv =====
interface cicd_req_if;
  import cicd_pkg::*;
  logic                valid;
  logic                ready;
  logic [CMD_W-1:0]    cmd;
  logic [POS_W-1:0]    pos_x;
  logic [POS_W-1:0]    pos_y;
  logic [CI_W-1:0]     cell_index;

  modport source (output valid, output cmd, output pos_x, output pos_y,
                  output cell_index, input ready);
  modport sink   (input valid, input cmd, input pos_x, input pos_y,
                  input cell_index, output ready);
endinterface

interface cicd_rsp_if;
  import cicd_pkg::*;
  logic                valid;
  logic                ready;
  logic [ACC_W-1:0]    cell_value;
  logic [STATUS_W-1:0] status;

  modport source (output valid, output cell_value, output status, input ready);
  modport sink   (input valid, input cell_value, input status, output ready);
endinterface

// ===== src/cic_charge_deposit_2d_unit.sv =====
// Requests: one at a time; back-to-back deposits are spaced by the work of the
//   shared multiplier (two position products, then two products per cell for four
//   cells) and the read-modify-write of each cell in one grid RAM.
// Reset: synchronous, active high; afterwards a clearing pass zeroes the grid,
//   with no request taken until it is done.
module cic_charge_deposit_2d_unit #(
  parameter int GRID_X = cicd_pkg::GRID_X_DEF,
  parameter int GRID_Y = cicd_pkg::GRID_Y_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  cicd_req_if.sink                       req,
  cicd_rsp_if.source                     rsp,
  input  logic                           cfg_we,
  input  logic [cicd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [cicd_pkg::CFG_W-1:0]     cfg_data
);
  import cicd_pkg::*;

  localparam int NCELLS = GRID_X * GRID_Y;
  localparam int ADDR_W = $clog2(NCELLS);

  // CLEAR : sweep the grid writing zero (after reset and on clear command)
  // MX/MY : position products come back from the multiplier
  // W1    : weight product wx*wy issued
  // W2    : times weight_scale issued, cell read issued
  // ACC   : saturating add, cell written back
  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_MX, S_MY, S_W1, S_W2, S_ACC, S_RDATA, S_RESP
  } state_t;

  state_t state;

  logic [CFG_W-1:0]    inv_cell;
  logic [CFG_W-1:0]    weight_scale;
  logic [POS_W-1:0]    py;
  logic [JW-1:0]       jx;
  logic [JW-1:0]       jy;
  logic [FRAC_W-1:0]   fx;
  logic [FRAC_W-1:0]   fy;
  logic [1:0]          k;          // neighbor cell being updated
  logic                sat;
  logic                clear_reply;
  logic [ADDR_W-1:0]   clear_pointer;
  logic [ACC_W-1:0]    res_value;
  logic [STATUS_W-1:0] res_status;
  logic                out_valid;
  logic [ACC_W-1:0]    out_value;
  logic [STATUS_W-1:0] out_status;

  mul_op_t             mul_op;
  logic [PROD_W-1:0]   prod;

  logic                grid_we;
  logic [ADDR_W-1:0]   grid_waddr;
  logic [ACC_W-1:0]    grid_wdata;
  logic [ADDR_W-1:0]   grid_raddr;
  logic [ACC_W-1:0]    grid_rdata;

  logic                req_fire;
  logic                out_free;
  logic [WGT_W-1:0]    wx;
  logic [WGT_W-1:0]    wy;
  logic [31:0]         cell_wide;
  logic [ADDR_W-1:0]   cell_addr;
  logic [31:0]         ci_wide;
  logic                ci_ok;
  logic [JW-1:0]       prod_int;
  logic                drop;
  logic [AMT_W-1:0]    amount;
  logic [ACC_W:0]      sum;
  logic                acc_sat;
  logic [ACC_W-1:0]    acc_value;

  assign req.ready  = (state == S_IDLE);
  assign req_fire   = req.valid && req.ready;
  assign out_free   = !out_valid || rsp.ready;

  assign rsp.valid      = out_valid;
  assign rsp.cell_value = out_value;
  assign rsp.status     = out_status;

  // bilinear weights: x side picks by k[0], y side by k[1]
  assign wx = k[0] ? {1'b0, fx} : ONE_Q16 - {1'b0, fx};
  assign wy = k[1] ? {1'b0, fy} : ONE_Q16 - {1'b0, fy};

  // neighbor order: base, base+GRID_Y, base+1, base+GRID_Y+1
  assign cell_wide = 32'(jx) * 32'(GRID_Y) + 32'(jy)
                   + (k[0] ? 32'(GRID_Y) : 32'd0) + (k[1] ? 32'd1 : 32'd0);
  assign cell_addr = cell_wide[ADDR_W-1:0];

  assign ci_wide = 32'(req.cell_index);
  assign ci_ok   = ci_wide < 32'(NCELLS);

  // upper neighbor must stay inside the grid
  assign prod_int = prod[INT_LO+JW-1:INT_LO];
  assign drop = (32'(jx) + 32'd1 >= 32'(GRID_X)) ||
                (32'(prod_int) + 32'd1 >= 32'(GRID_Y));

  assign amount    = prod[INT_LO+AMT_W-1:INT_LO];
  assign sum       = {1'b0, grid_rdata} + (ACC_W+1)'(amount);
  assign acc_sat   = sum[ACC_W];
  assign acc_value = acc_sat ? '1 : sum[ACC_W-1:0];

  // multiplier operand select
  always_comb begin
    mul_op = '0;
    case (state)
      S_IDLE: begin
        mul_op.a = MUL_A_W'(req.pos_x);
        mul_op.b = inv_cell;
      end
      S_MX: begin
        mul_op.a = MUL_A_W'(py);
        mul_op.b = inv_cell;
      end
      S_W1: begin
        mul_op.a = MUL_A_W'(wx);
        mul_op.b = MUL_B_W'(wy);
      end
      S_W2: begin
        mul_op.a = prod[MUL_A_W-1:0];
        mul_op.b = weight_scale;
      end
      default: begin
        mul_op = '0;
      end
    endcase
  end

  always_comb begin
    grid_we    = (state == S_ACC) || (state == S_CLEAR);
    grid_waddr = (state == S_CLEAR) ? clear_pointer : cell_addr;
    grid_wdata = (state == S_CLEAR) ? '0 : acc_value;
    grid_raddr = (state == S_IDLE) ? ci_wide[ADDR_W-1:0] : cell_addr;
  end

  cicd_mul u_mul (
    .clk  (clk),
    .op   (mul_op),
    .prod (prod)
  );

  cicd_grid #(
    .DEPTH  (NCELLS),
    .ADDR_W (ADDR_W)
  ) u_grid (
    .clk   (clk),
    .we    (grid_we),
    .waddr (grid_waddr),
    .wdata (grid_wdata),
    .raddr (grid_raddr),
    .rdata (grid_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      clear_pointer <= '0;
      clear_reply   <= 1'b0;
      out_valid     <= 1'b0;
      k             <= '0;
      sat           <= 1'b0;
      inv_cell      <= INV_CELL_RST;
      weight_scale  <= WEIGHT_SCALE_RST;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_INV_CELL:     inv_cell     <= cfg_data;
          REG_WEIGHT_SCALE: weight_scale <= cfg_data;
          default: ;
        endcase
      end

      // output register: load a new result, or drop the one just taken
      if (state == S_RESP && out_free) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_CLEAR: begin
          if (clear_pointer == ADDR_W'(NCELLS - 1)) begin
            clear_pointer <= '0;
            if (clear_reply) begin
              clear_reply <= 1'b0;
              res_value   <= '0;
              res_status  <= ST_OK;
              state       <= S_RESP;
            end else begin
              state <= S_IDLE;
            end
          end else begin
            clear_pointer <= clear_pointer + ADDR_W'(1);
          end
        end
        S_IDLE: begin
          if (req_fire) begin
            py         <= req.pos_y;
            res_value  <= '0;
            case (req.cmd)
              CMD_CLEAR: begin
                res_status  <= ST_OK;
                clear_reply <= 1'b1;
                state       <= S_CLEAR;
              end
              CMD_DEPOSIT: begin
                res_status <= ST_OK;
                state      <= S_MX;
              end
              CMD_READ: begin
                if (ci_ok) begin
                  res_status <= ST_OK;
                  state      <= S_RDATA;
                end else begin
                  res_status <= ST_DROP;
                  state      <= S_RESP;
                end
              end
              default: begin
                res_status <= ST_OK;
                state      <= S_RESP;
              end
            endcase
          end
        end
        S_MX: begin
          jx    <= prod_int;
          fx    <= prod[FRAC_LO+FRAC_W-1:FRAC_LO];
          state <= S_MY;
        end
        S_MY: begin
          jy  <= prod_int;
          fy  <= prod[FRAC_LO+FRAC_W-1:FRAC_LO];
          k   <= '0;
          sat <= 1'b0;
          if (drop) begin
            res_status <= ST_DROP;
            state      <= S_RESP;
          end else begin
            state <= S_W1;
          end
        end
        S_W1: begin
          state <= S_W2;
        end
        S_W2: begin
          state <= S_ACC;
        end
        S_ACC: begin
          sat <= sat | acc_sat;
          k   <= k + 2'd1;
          if (k == 2'd3) begin
            res_status <= (sat | acc_sat) ? ST_SAT : ST_OK;
            state      <= S_RESP;
          end else begin
            state <= S_W1;
          end
        end
        S_RDATA: begin
          res_value <= grid_rdata;
          state     <= S_RESP;
        end
        S_RESP: begin
          if (out_free) begin
            out_value  <= res_value;
            out_status <= res_status;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // grid is written only by the sweep or the accumulate step
  a_grid_we_src: assert property (@(posedge clk) disable iff (rst)
    grid_we |-> (state == S_ACC || state == S_CLEAR))
    else $error("grid write outside sweep or accumulate");

  // fourth neighbor ends the deposit
  a_dep_done: assert property (@(posedge clk) disable iff (rst)
    (state == S_ACC && k == 2'd3) |=> (state == S_RESP))
    else $error("deposit did not finish after fourth cell");

  // non-ok results carry no density
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.status != ST_OK) |-> (rsp.cell_value == '0))
    else $error("error result with nonzero value");

  // reset always starts the clearing pass
  a_rst_clear: assert property (@(posedge clk)
    rst |=> (state == S_CLEAR && clear_pointer == '0 && !out_valid))
    else $error("reset did not start clearing pass");

endmodule

// ===== src/cicd_mul.sv =====
module cicd_mul (
  input  logic                     clk,
  input  cicd_pkg::mul_op_t        op,
  output logic [cicd_pkg::PROD_W-1:0] prod
);
  import cicd_pkg::*;

  // product is registered, ready in the cycle after the operands
  always_ff @(posedge clk) begin
    prod <= PROD_W'(op.a) * PROD_W'(op.b);
  end

endmodule

// ===== src/cicd_grid.sv =====
module cicd_grid #(
  parameter int DEPTH  = cicd_pkg::GRID_X_DEF * cicd_pkg::GRID_Y_DEF,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [ADDR_W-1:0]          waddr,
  input  logic [cicd_pkg::ACC_W-1:0] wdata,
  input  logic [ADDR_W-1:0]          raddr,
  output logic [cicd_pkg::ACC_W-1:0] rdata
);
  import cicd_pkg::*;

  logic [ACC_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

// Testbench for the 2D cloud-in-cell charge deposition unit.
// Requests (clear / deposit / read / spare command) are queued by the main
// initial block, driven at the falling edge by a random-idle driver, and
// predicted at the accepting rising edge against a local copy of the density
// grid. Responses are taken by a random-stall monitor and checked in order.
// Register settings change only between phases, once the block is drained.
module tb_top;
  import cicd_pkg::*;

  localparam int NCELLS = GRID_X_DEF * GRID_Y_DEF;
  localparam logic [ACC_W-1:0] ACC_MAX = '1;
  // The command encoding leaves code 3 unused; the block must answer it with zeros.
  localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;
  localparam int IDLE_PCT = 16;
  // Longest quiet stretch is a clear or the post-reset sweep.
  localparam int WATCHDOG_LIMIT = 20000;
  // Cycles let pass after the last response before a register write or the end.
  localparam int SETTLE = 40;
  localparam int PHASE_ITEMS = 190;
  localparam int NPHASES = 7;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;
    logic [CI_W-1:0]  cell_index;
  } cic_req_t;

  typedef struct packed {
    logic [ACC_W-1:0]    cell_value;
    logic [STATUS_W-1:0] status;
  } cic_rsp_t;

  logic clk = 1'b0;
  logic rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  cicd_req_if req ();
  cicd_rsp_if rsp ();

  cic_charge_deposit_2d_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .rsp       (rsp),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Shadow state of the block: grid contents and the two registers
  // ---------------------------------------------------------------------------
  logic [ACC_W-1:0] density_model [NCELLS];
  logic [CFG_W-1:0] inv_cell_q;
  logic [CFG_W-1:0] weight_scale_q;

  cic_req_t pending_reqs[$];       // requests waiting for the driver
  cic_rsp_t cell_results_due[$];   // predicted responses, oldest first

  int  mismatch_count = 0;
  int  quiet_cycles = 0;
  int  last_base = 0;              // base cell of the latest in-grid deposit
  bit  req_taken = 1'b0;
  bit  calm = 1'b0;                // no idling on either side while set

  // Adds one bilinear weight product to a cell; returns 1 when it clips.
  function automatic logic add_weight(int idx, logic [63:0] wa, logic [63:0] wb);
    logic [63:0] amount;
    logic [63:0] sum;
    amount = (wa * wb * 64'(weight_scale_q)) >> 32;
    sum = 64'(density_model[idx]) + amount;
    if (sum > 64'(ACC_MAX)) begin
      density_model[idx] = ACC_MAX;
      return 1'b1;
    end
    density_model[idx] = sum[ACC_W-1:0];
    return 1'b0;
  endfunction

  // Response of one request; updates the shadow grid as the block would.
  function automatic cic_rsp_t deposit_response(cic_req_t r);
    cic_rsp_t    res;
    logic [63:0] prx, pry, fx, fy, gx0, gy0;
    int          jx, jy, base;
    logic        sat;
    res.cell_value = '0;
    res.status = ST_OK;
    case (r.cmd)
      CMD_CLEAR: begin
        foreach (density_model[i]) density_model[i] = '0;
      end
      CMD_DEPOSIT: begin
        // Q8.16 position times Q2.16 reciprocal -> Q10.32
        prx = 64'(r.pos_x) * 64'(inv_cell_q);
        pry = 64'(r.pos_y) * 64'(inv_cell_q);
        jx = int'(prx >> INT_LO);
        jy = int'(pry >> INT_LO);
        fx = (prx >> FRAC_LO) & 64'hFFFF;
        fy = (pry >> FRAC_LO) & 64'hFFFF;
        // upper neighbour must stay inside the grid, else the particle is dropped
        if (jx + 1 >= GRID_X_DEF || jy + 1 >= GRID_Y_DEF) begin
          res.status = ST_DROP;
        end else begin
          base = jx * GRID_Y_DEF + jy;
          gx0 = 64'd65536 - fx;
          gy0 = 64'd65536 - fy;
          sat = 1'b0;
          sat |= add_weight(base, gx0, gy0);
          sat |= add_weight(base + GRID_Y_DEF, fx, gy0);
          sat |= add_weight(base + 1, gx0, fy);
          sat |= add_weight(base + GRID_Y_DEF + 1, fx, fy);
          if (sat) res.status = ST_SAT;
        end
      end
      CMD_READ: begin
        if (int'(r.cell_index) < NCELLS) res.cell_value = density_model[r.cell_index];
        else res.status = ST_DROP;
      end
      CMD_SPARE: ;
    endcase
    return res;
  endfunction

  task automatic report_mismatch(string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Request driver: new request only after the previous one was taken
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin : drive_req
    cic_req_t nxt;
    if (rst) begin
      req.valid <= 1'b0;
    end else if (!req.valid || req_taken) begin
      if (pending_reqs.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
        nxt = pending_reqs.pop_front();
        req.valid      <= 1'b1;
        req.cmd        <= nxt.cmd;
        req.pos_x      <= nxt.pos_x;
        req.pos_y      <= nxt.pos_y;
        req.cell_index <= nxt.cell_index;
      end else begin
        req.valid <= 1'b0;
      end
    end
    req_taken = 1'b0;
  end

  // response back-pressure
  always @(negedge clk) begin
    rsp.ready <= !rst && (calm || $urandom_range(0, 99) >= IDLE_PCT);
  end

  // ---------------------------------------------------------------------------
  // Monitor: predict on request, compare on response
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : watch
    cic_req_t seen;
    cic_rsp_t want;
    if (!rst) begin
      if (req.valid && req.ready) begin
        req_taken = 1'b1;
        seen = '{req.cmd, req.pos_x, req.pos_y, req.cell_index};
        cell_results_due.push_back(deposit_response(seen));
      end
      if (rsp.valid && rsp.ready) begin
        if (cell_results_due.size() == 0) begin
          report_mismatch($sformatf("response with nothing outstanding (value %0h status %0d)",
                                    rsp.cell_value, rsp.status));
        end else begin
          want = cell_results_due.pop_front();
          if (rsp.cell_value !== want.cell_value)
            report_mismatch($sformatf("cell_value %0h, predicted %0h",
                                      rsp.cell_value, want.cell_value));
          if (rsp.status !== want.status)
            report_mismatch($sformatf("status %0d, predicted %0d", rsp.status, want.status));
        end
      end
    end
  end

  // Watchdog: cycles with no handshake on either channel
  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
      $display("tb_top NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic push_req(logic [CMD_W-1:0] cmd, logic [POS_W-1:0] px,
                          logic [POS_W-1:0] py, logic [CI_W-1:0] ci);
    pending_reqs.push_back('{cmd, px, py, ci});
  endtask

  // Mostly deposits that land inside the grid for the current reciprocal,
  // reads biased to the cells just hit, a few clears and spare commands.
  task automatic push_random(int n);
    cic_req_t    r;
    int          roll;
    logic [63:0] lim_x, lim_y, prx, pry;
    for (int i = 0; i < n; i++) begin
      roll = $urandom_range(0, 999);
      r.pos_x = POS_W'($urandom);
      r.pos_y = POS_W'($urandom);
      r.cell_index = CI_W'($urandom);
      if (roll < 7) begin
        r.cmd = CMD_CLEAR;
      end else if (roll < 27) begin
        r.cmd = CMD_SPARE;
      end else if (roll < 290) begin
        r.cmd = CMD_READ;
        if ($urandom_range(0, 1) == 1)
          r.cell_index = CI_W'(last_base + ($urandom_range(0, 1) * GRID_Y_DEF)
                               + $urandom_range(0, 1));
      end else begin
        r.cmd = CMD_DEPOSIT;
        if ($urandom_range(0, 9) < 8) begin
          // keep index + 1 below the grid edge on both axes
          lim_x = (inv_cell_q == '0) ? 64'hFFFFFF
                : ((64'(GRID_X_DEF - 1) << 32) - 1) / 64'(inv_cell_q);
          lim_y = (inv_cell_q == '0) ? 64'hFFFFFF
                : ((64'(GRID_Y_DEF - 1) << 32) - 1) / 64'(inv_cell_q);
          if (lim_x > 64'hFFFFFF) lim_x = 64'hFFFFFF;
          if (lim_y > 64'hFFFFFF) lim_y = 64'hFFFFFF;
          r.pos_x = POS_W'($urandom_range(0, int'(lim_x)));
          r.pos_y = POS_W'($urandom_range(0, int'(lim_y)));
        end
        prx = 64'(r.pos_x) * 64'(inv_cell_q);
        pry = 64'(r.pos_y) * 64'(inv_cell_q);
        if ((prx >> INT_LO) + 1 < GRID_X_DEF && (pry >> INT_LO) + 1 < GRID_Y_DEF)
          last_base = int'(prx >> INT_LO) * GRID_Y_DEF + int'(pry >> INT_LO);
      end
      pending_reqs.push_back(r);
    end
  endtask

  // Register write; the shadow copy is updated once the write strobe is dropped.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_INV_CELL:     inv_cell_q = val;
      REG_WEIGHT_SCALE: weight_scale_q = val;
    endcase
  endtask

  // Block is idle once every request went out and every response came back.
  task automatic wait_drained();
    while (pending_reqs.size() != 0 || req.valid || cell_results_due.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin : main_seq
    logic [CFG_W-1:0] inv_set [NPHASES];
    logic [CFG_W-1:0] scale_set [NPHASES];

    req.valid = 1'b0;
    req.cmd = CMD_CLEAR;
    req.pos_x = '0;
    req.pos_y = '0;
    req.cell_index = '0;
    rsp.ready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_INV_CELL;
    cfg_data = '0;
    inv_cell_q = INV_CELL_RST;
    weight_scale_q = WEIGHT_SCALE_RST;
    foreach (density_model[i]) density_model[i] = '0;

    rst = 1'b1;
    repeat (9) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // directed part, reset register values
    push_req(CMD_READ,    24'h0,      24'h0,      10'd0);    // grid starts at zero
    push_req(CMD_DEPOSIT, 24'h0,      24'h0,      10'd0);    // whole weight on cell 0
    push_req(CMD_READ,    24'h0,      24'h0,      10'd0);
    push_req(CMD_DEPOSIT, 24'h008000, 24'h00C000, 10'd0);    // split over four cells
    push_req(CMD_READ,    24'h0,      24'h0,      10'd1);
    push_req(CMD_READ,    24'h0,      24'h0,      10'd16);
    push_req(CMD_READ,    24'h0,      24'h0,      10'd17);
    push_req(CMD_DEPOSIT, 24'h3D8000, 24'h0E8000, 10'd0);    // last in-grid corner
    push_req(CMD_READ,    24'h0,      24'h0,      10'd1007);
    push_req(CMD_DEPOSIT, 24'h3F0000, 24'h010000, 10'd0);    // x neighbour off the edge
    push_req(CMD_DEPOSIT, 24'h010000, 24'h0F0000, 10'd0);    // y neighbour off the edge
    push_req(CMD_DEPOSIT, 24'hFFFFFF, 24'hFFFFFF, 10'h3FF);  // far outside
    push_req(CMD_SPARE,   24'hFFFFFF, 24'hFFFFFF, 10'h3FF);  // unused code: no effect
    push_req(CMD_READ,    24'hFFFFFF, 24'hFFFFFF, 10'h3FF);  // highest cell index
    push_req(CMD_CLEAR,   24'hFFFFFF, 24'hFFFFFF, 10'h3FF);
    push_req(CMD_READ,    24'h0,      24'h0,      10'd0);
    push_req(CMD_READ,    24'h0,      24'h0,      10'd1007);
    push_req(CMD_DEPOSIT, 24'h00FFFF, 24'h00FFFF, 10'd0);    // position fraction near one
    push_req(CMD_READ,    24'h0,      24'h0,      10'd17);
    push_random(200);
    wait_drained();

    // register sweeps: extremes on both, unit values, one random pair,
    // then back to the reset values
    inv_set   = '{18'd0,      18'h3FFFF, 18'h3FFFF, 18'd1, 18'd65536, 18'd0, INV_CELL_RST};
    scale_set = '{18'h3FFFF,  18'd0,     18'h3FFFF, 18'd1, 18'd65536, 18'd0, WEIGHT_SCALE_RST};
    inv_set[5]   = CFG_W'($urandom);
    scale_set[5] = CFG_W'($urandom);

    for (int p = 0; p < NPHASES; p++) begin
      write_reg(REG_INV_CELL, inv_set[p]);
      write_reg(REG_WEIGHT_SCALE, scale_set[p]);
      calm = (p == 3);   // one long stretch with both sides always ready
      push_random(PHASE_ITEMS);
      wait_drained();
    end
    calm = 1'b0;

    if (mismatch_count == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
